### rtl/point_in_tetrahedron_test_macros.svh
// ----------------------------------------------------------------------------
// Point in tetrahedron test: assertion macros
// Concurrent assertion wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_TETRAHEDRON_TEST_MACROS_SVH
`define POINT_IN_TETRAHEDRON_TEST_MACROS_SVH

// same-cycle implication, masked while rst is high
`define PITT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, never masked
`define PITT_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pitt_pkg.sv
// ----------------------------------------------------------------------------
// Point in tetrahedron test: package
// Shared constants, types and the final classification function.
// ----------------------------------------------------------------------------
`default_nettype none

package pitt_pkg;

   localparam int FIELD_BITS         = 48;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int LOCATION_BITS      = 2;
   localparam int ORIENT_STAGES      = 6;
   localparam int NUM_POINTS         = 5;
   localparam int NUM_FACES          = 4;

   typedef enum logic [LOCATION_BITS-1:0] {
      LOC_INSIDE     = 2'd0,
      LOC_BOUNDARY   = 2'd1,
      LOC_OUTSIDE    = 2'd2,
      LOC_DEGENERATE = 2'd3
   } location_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

   // face vertex indices (a=0 .. d=3); opposite vertex index equals face index
   localparam logic [2:0] FACE_VERTEX [NUM_FACES][3] = '{
      '{3'd1, 3'd2, 3'd3},
      '{3'd0, 3'd3, 3'd2},
      '{3'd0, 3'd1, 3'd3},
      '{3'd0, 3'd2, 3'd1}
   };
   localparam logic [2:0] QUERY_INDEX = 3'd4;

   function automatic location_type classify(input sign_type [NUM_FACES-1:0] vert,
                                             input sign_type [NUM_FACES-1:0] qry);
      logic degen;
      logic outside;
      logic touch;
      degen   = 1'b0;
      outside = 1'b0;
      touch   = 1'b0;
      for (int f = 0; f < NUM_FACES; f++) begin
         if (vert[f].zero) degen = 1'b1;
         if (qry[f].zero) touch = 1'b1;
         else if (qry[f].neg != vert[f].neg) outside = 1'b1;
      end
      if (degen) return LOC_DEGENERATE;
      if (outside) return LOC_OUTSIDE;
      if (touch) return LOC_BOUNDARY;
      return LOC_INSIDE;
   endfunction

endpackage

`default_nettype wire

### rtl/pitt_orient.sv
// ----------------------------------------------------------------------------
// Point in tetrahedron test: orientation pipeline
// Exact sign of det(p0-p3, p1-p3, p2-p3) in six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pitt_orient #(
   parameter int COORD_BITS = pitt_pkg::COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [3*COORD_BITS-1:0] p0,
   input  logic [3*COORD_BITS-1:0] p1,
   input  logic [3*COORD_BITS-1:0] p2,
   input  logic [3*COORD_BITS-1:0] p3,
   output pitt_pkg::sign_type      sign
);
   import pitt_pkg::*;

   localparam int DW  = COORD_BITS + 1;   // difference
   localparam int PW  = 2 * DW;           // 2x2 product
   localparam int MW  = PW + 1;           // minor
   localparam int K   = DW + 1;           // low split of minor
   localparam int HMW = MW - K;           // high part of minor
   localparam int LPW = K + 1 + DW;       // low partial product
   localparam int HPW = HMW + DW;         // high partial product
   localparam int LW  = LPW + 2;
   localparam int HW  = HPW + 2;
   localparam int TW  = K + HW + 1;

   // stage 1: differences
   logic signed [DW-1:0] a_in [3], b_in [3], c_in [3];
   logic signed [DW-1:0] a_ff [3], b_ff [3], c_ff [3];

   for (genvar k = 0; k < 3; k++) begin : g_diff
      assign a_in[k] = DW'($signed(p0[k*COORD_BITS +: COORD_BITS]))
                     - DW'($signed(p3[k*COORD_BITS +: COORD_BITS]));
      assign b_in[k] = DW'($signed(p1[k*COORD_BITS +: COORD_BITS]))
                     - DW'($signed(p3[k*COORD_BITS +: COORD_BITS]));
      assign c_in[k] = DW'($signed(p2[k*COORD_BITS +: COORD_BITS]))
                     - DW'($signed(p3[k*COORD_BITS +: COORD_BITS]));
   end

   // stage 2: 2x2 products
   logic signed [PW-1:0] pr_in [6];
   logic signed [PW-1:0] pr_ff [6];
   logic signed [DW-1:0] a2_ff [3];

   assign pr_in[0] = PW'(b_ff[1]) * PW'(c_ff[2]);
   assign pr_in[1] = PW'(b_ff[2]) * PW'(c_ff[1]);
   assign pr_in[2] = PW'(b_ff[0]) * PW'(c_ff[2]);
   assign pr_in[3] = PW'(b_ff[2]) * PW'(c_ff[0]);
   assign pr_in[4] = PW'(b_ff[0]) * PW'(c_ff[1]);
   assign pr_in[5] = PW'(b_ff[1]) * PW'(c_ff[0]);

   // stage 3: minors
   logic signed [MW-1:0] m_in [3];
   logic signed [MW-1:0] m_ff [3];
   logic signed [DW-1:0] a3_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_minor
      assign m_in[i] = MW'(pr_ff[2*i]) - MW'(pr_ff[2*i+1]);
   end

   // stage 4: split partial products
   logic signed [LPW-1:0] lo_in [3], lo_ff [3];
   logic signed [HPW-1:0] hi_in [3], hi_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_part
      assign lo_in[i] = LPW'($signed({1'b0, m_ff[i][K-1:0]})) * LPW'(a3_ff[i]);
      assign hi_in[i] = HPW'($signed(m_ff[i][MW-1:K])) * HPW'(a3_ff[i]);
   end

   // stage 5: column sums
   logic signed [LW-1:0] lsum_in, lsum_ff;
   logic signed [HW-1:0] hsum_in, hsum_ff;

   assign lsum_in = LW'(lo_ff[0]) - LW'(lo_ff[1]) + LW'(lo_ff[2]);
   assign hsum_in = HW'(hi_ff[0]) - HW'(hi_ff[1]) + HW'(hi_ff[2]);

   // stage 6: recombine and take sign
   logic signed [TW-1:0] total;
   sign_type             sign_in, sign_ff;

   assign total        = (TW'(hsum_ff) <<< K) + TW'(lsum_ff);
   assign sign_in.neg  = total[TW-1];
   assign sign_in.zero = (total == '0);

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         pr_ff   <= pr_in;
         a2_ff   <= a_ff;
         m_ff    <= m_in;
         a3_ff   <= a2_ff;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         lsum_ff <= lsum_in;
         hsum_ff <= hsum_in;
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

endmodule

`default_nettype wire

### rtl/point_in_tetrahedron_test.sv
// ----------------------------------------------------------------------------
// Point in tetrahedron test: top level, eight orientation pipelines + classify
// Request to response passes 6 orientation stages, then 1 output register.
// Throughput: 1 request per cycle; a held response stalls the whole pipeline.
// Reset: synchronous, clears valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_in_tetrahedron_test_macros.svh"

module point_in_tetrahedron_test #(
   parameter int COORD_BITS = pitt_pkg::COORD_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pitt_pkg::FIELD_BITS-1:0]  req_vertex_a,
   input  logic [pitt_pkg::FIELD_BITS-1:0]  req_vertex_b,
   input  logic [pitt_pkg::FIELD_BITS-1:0]  req_vertex_c,
   input  logic [pitt_pkg::FIELD_BITS-1:0]  req_vertex_d,
   input  logic [pitt_pkg::FIELD_BITS-1:0]  req_query_point,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pitt_pkg::LOCATION_BITS-1:0] rsp_location
);
   import pitt_pkg::*;

   localparam int PACK = 3 * COORD_BITS;

   logic                                 en;
   logic [PACK-1:0]                      pt [NUM_POINTS];
   sign_type [NUM_FACES-1:0]             vert_sign;
   sign_type [NUM_FACES-1:0]             qry_sign;
   logic [ORIENT_STAGES-1:0]             vld_ff, vld_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   location_type                         rsp_location_ff, rsp_location_in;

   // coordinates above the 48-bit field read as zero
   assign pt[0] = PACK'(req_vertex_a);
   assign pt[1] = PACK'(req_vertex_b);
   assign pt[2] = PACK'(req_vertex_c);
   assign pt[3] = PACK'(req_vertex_d);
   assign pt[4] = PACK'(req_query_point);

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
      pitt_orient #(.COORD_BITS(COORD_BITS)) u_vert (
         .clock (clock),
         .en    (en),
         .p0    (pt[FACE_VERTEX[f][0]]),
         .p1    (pt[FACE_VERTEX[f][1]]),
         .p2    (pt[FACE_VERTEX[f][2]]),
         .p3    (pt[f]),
         .sign  (vert_sign[f])
      );
      pitt_orient #(.COORD_BITS(COORD_BITS)) u_qry (
         .clock (clock),
         .en    (en),
         .p0    (pt[FACE_VERTEX[f][0]]),
         .p1    (pt[FACE_VERTEX[f][1]]),
         .p2    (pt[FACE_VERTEX[f][2]]),
         .p3    (pt[QUERY_INDEX]),
         .sign  (qry_sign[f])
      );
   end

   assign vld_in          = {vld_ff[ORIENT_STAGES-2:0], req_valid};
   assign rsp_valid_in    = vld_ff[ORIENT_STAGES-1];
   assign rsp_location_in = classify(vert_sign, qry_sign);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_location_ff <= rsp_location_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_location = rsp_location_ff;

   `PITT_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken while response stalled")
   `PITT_ASSERT_IMPLY(a_free_out_ready, clock, reset, !rsp_valid, req_ready, "pipeline stalled with empty output")
   `PITT_ASSERT_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid, "response valid after reset")

endmodule

`default_nettype wire

### verif/point_in_tetrahedron_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point in tetrahedron test: self-checking testbench
// Streams tetrahedron/query requests through the block under bursty input
// and a stalling output, predicts each location from exact integer
// orientation determinants, and checks every response in order.
// ----------------------------------------------------------------------------

module point_in_tetrahedron_test_test;
   import pitt_pkg::*;

   localparam int CB     = COORD_BITS_DEFAULT;
   localparam int FB     = FIELD_BITS;
   localparam int C_MAX  = (1 << (CB - 1)) - 1;
   localparam int C_MIN  = -(1 << (CB - 1));
   localparam int N_RAND = 1200;

   typedef logic signed [127:0] wint_type;
   typedef struct { wint_type x; wint_type y; wint_type z; } wpoint_type;
   typedef struct { int x; int y; int z; } ipoint_type;
   typedef struct packed {
      logic [FB-1:0] a;
      logic [FB-1:0] b;
      logic [FB-1:0] c;
      logic [FB-1:0] d;
      logic [FB-1:0] q;
   } tet_query_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [FB-1:0] req_vertex_a = '0;
   logic [FB-1:0] req_vertex_b = '0;
   logic [FB-1:0] req_vertex_c = '0;
   logic [FB-1:0] req_vertex_d = '0;
   logic [FB-1:0] req_query_point = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [LOCATION_BITS-1:0] rsp_location;

   tet_query_type pending_queries[$];
   location_type  expected_locations[$];
   tet_query_type offered;
   int            total_queries = 0;
   int            burst_left = 1;
   int            idle_gap = 0;
   int            accepted_count = 0;
   int            error_count = 0;
   int            location_tally[4] = '{0, 0, 0, 0};
   int            hold_left = 0;
   int            holds_done = 0;
   int            hold_cycles_total = 0;
   int            rx_mode = 0;
   int            rx_mode_left = 0;
   logic [7:0]    rx_mask = 8'h5b;

   point_in_tetrahedron_test #(.COORD_BITS(CB)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .req_vertex_c   (req_vertex_c),
      .req_vertex_d   (req_vertex_d),
      .req_query_point(req_query_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_location   (rsp_location)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #200000;
      $display("FAIL point_in_tetrahedron_test");
      $finish;
   end

   // ---------------- prediction ----------------

   function automatic wpoint_type unpack_point(logic [FB-1:0] v);
      logic [63:0] word;
      logic [63:0] raw;
      wint_type    coord [3];
      wpoint_type  p;
      word = {{(64 - FB){1'b0}}, v};
      for (int k = 0; k < 3; k++) begin
         raw = (word >> (k * CB)) & ((64'd1 << CB) - 64'd1);
         coord[k] = {64'd0, raw};
         if (raw[CB-1]) coord[k] = coord[k] - (128'sd1 <<< CB);
      end
      p.x = coord[0];
      p.y = coord[1];
      p.z = coord[2];
      return p;
   endfunction

   // sign of det(p0-p3, p1-p3, p2-p3)
   function automatic int orientation(wpoint_type p0, wpoint_type p1, wpoint_type p2,
                                      wpoint_type p3);
      wint_type ax, ay, az, bx, by, bz, cx, cy, cz, det;
      ax = p0.x - p3.x;  ay = p0.y - p3.y;  az = p0.z - p3.z;
      bx = p1.x - p3.x;  by = p1.y - p3.y;  bz = p1.z - p3.z;
      cx = p2.x - p3.x;  cy = p2.y - p3.y;  cz = p2.z - p3.z;
      det = ax * (by * cz - bz * cy) - ay * (bx * cz - bz * cx) + az * (bx * cy - by * cx);
      if (det < 0) return -1;
      if (det == 0) return 0;
      return 1;
   endfunction

   function automatic location_type locate_query(tet_query_type r);
      wpoint_type a, b, c, d, q;
      int         vert_sign [4];
      int         qry_sign [4];
      logic       outside;
      logic       touch;
      a = unpack_point(r.a);
      b = unpack_point(r.b);
      c = unpack_point(r.c);
      d = unpack_point(r.d);
      q = unpack_point(r.q);
      vert_sign[0] = orientation(b, c, d, a);
      vert_sign[1] = orientation(a, d, c, b);
      vert_sign[2] = orientation(a, b, d, c);
      vert_sign[3] = orientation(a, c, b, d);
      qry_sign[0]  = orientation(b, c, d, q);
      qry_sign[1]  = orientation(a, d, c, q);
      qry_sign[2]  = orientation(a, b, d, q);
      qry_sign[3]  = orientation(a, c, b, q);
      outside = 1'b0;
      touch   = 1'b0;
      for (int f = 0; f < 4; f++) begin
         if (vert_sign[f] == 0) return LOC_DEGENERATE;
      end
      for (int f = 0; f < 4; f++) begin
         if (qry_sign[f] == 0) touch = 1'b1;
         else if (qry_sign[f] != vert_sign[f]) outside = 1'b1;
      end
      if (outside) return LOC_OUTSIDE;
      if (touch) return LOC_BOUNDARY;
      return LOC_INSIDE;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic ipoint_type pt(int x, int y, int z);
      ipoint_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   function automatic logic [FB-1:0] pack_point(ipoint_type p);
      logic [63:0] mask;
      logic [63:0] acc;
      mask = (64'd1 << CB) - 64'd1;
      acc = ({32'd0, p.x} & mask) | (({32'd0, p.y} & mask) << CB)
          | (({32'd0, p.z} & mask) << (2 * CB));
      return acc[FB-1:0];
   endfunction

   function automatic int rand_coord(int r);
      return int'($urandom_range(0, 2 * r)) - r;
   endfunction

   function automatic ipoint_type rand_point(int r);
      return pt(rand_coord(r), rand_coord(r), rand_coord(r));
   endfunction

   function automatic int extreme_coord();
      case ($urandom_range(0, 4))
         0: return C_MIN;
         1: return C_MAX;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   function automatic ipoint_type extreme_point();
      return pt(extreme_coord(), extreme_coord(), extreme_coord());
   endfunction

   function automatic int pick_range();
      case ($urandom_range(0, 3))
         0: return 8;
         1: return 100;
         2: return 3000;
         default: return 10000;
      endcase
   endfunction

   function automatic ipoint_type even_point(ipoint_type p);
      return pt(p.x & ~1, p.y & ~1, p.z & ~1);
   endfunction

   function automatic ipoint_type mid_point(ipoint_type u, ipoint_type v);
      return pt((u.x + v.x) >>> 1, (u.y + v.y) >>> 1, (u.z + v.z) >>> 1);
   endfunction

   function automatic logic [FB-1:0] rand_word();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[FB-1:0];
   endfunction

   task automatic add_query(ipoint_type a, ipoint_type b, ipoint_type c, ipoint_type d,
                            ipoint_type q);
      tet_query_type r;
      r.a = pack_point(a);
      r.b = pack_point(b);
      r.c = pack_point(c);
      r.d = pack_point(d);
      r.q = pack_point(q);
      pending_queries.push_back(r);
   endtask

   task automatic add_random_query();
      ipoint_type    a, b, c, d, q;
      tet_query_type r;
      int            sel;
      int            rng;
      sel = $urandom_range(0, 99);
      rng = pick_range();
      a = rand_point(rng);
      b = rand_point(rng);
      c = rand_point(rng);
      d = rand_point(rng);
      q = rand_point(rng);
      if (sel < 20) begin
         r.a = rand_word();
         r.b = rand_word();
         r.c = rand_word();
         r.d = rand_word();
         r.q = rand_word();
         pending_queries.push_back(r);
         return;
      end else if (sel < 45) begin
         rng = $urandom_range(1, 6);
         a = rand_point(rng);
         b = rand_point(rng);
         c = rand_point(rng);
         d = rand_point(rng);
         q = rand_point(rng);
      end else if (sel < 70) begin
         q = pt((a.x + b.x + c.x + d.x) >>> 2, (a.y + b.y + c.y + d.y) >>> 2,
                (a.z + b.z + c.z + d.z) >>> 2);
         if ($urandom_range(0, 2) == 0) q = pt(q.x + rand_coord(1), q.y + rand_coord(1),
                                               q.z + rand_coord(1));
      end else if (sel < 85) begin
         a = even_point(a);
         b = even_point(b);
         c = even_point(c);
         d = even_point(d);
         case ($urandom_range(0, 5))
            0: q = a;
            1: q = d;
            2: q = mid_point(a, b);
            3: q = mid_point(c, d);
            4: q = mid_point(b, c);
            default: q = mid_point(a, d);
         endcase
      end else if (sel < 95) begin
         case ($urandom_range(0, 2))
            0: d = a;
            1: d = pt(2 * b.x - a.x, 2 * b.y - a.y, 2 * b.z - a.z);
            default: d = pt(b.x + c.x - a.x, b.y + c.y - a.y, b.z + c.z - a.z);
         endcase
      end else begin
         a = extreme_point();
         b = extreme_point();
         c = extreme_point();
         d = extreme_point();
         q = extreme_point();
      end
      add_query(a, b, c, d, q);
   endtask

   // ---------------- test sequence ----------------

   initial begin
      tet_query_type ones;
      // small right-angle tetrahedron
      add_query(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(0, 0, 10), pt(1, 1, 1));
      add_query(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(0, 0, 10), pt(0, 0, 0));
      add_query(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(0, 0, 10), pt(5, 0, 0));
      add_query(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(0, 0, 10), pt(2, 2, 0));
      add_query(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(0, 0, 10), pt(3, 3, 4));
      add_query(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(0, 0, 10), pt(20, 20, 20));
      add_query(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(0, 0, 10), pt(-1, 1, 1));
      // mirrored vertex order
      add_query(pt(0, 0, 0), pt(0, 10, 0), pt(10, 0, 0), pt(0, 0, 10), pt(1, 1, 1));
      add_query(pt(0, 0, 0), pt(0, 10, 0), pt(10, 0, 0), pt(0, 0, 10), pt(1, 1, -1));
      // flat tetrahedra
      add_query(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0));
      add_query(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(5, 5, 0), pt(1, 1, 1));
      add_query(pt(0, 0, 0), pt(4, 4, 4), pt(8, 8, 8), pt(0, 0, 9), pt(1, 1, 1));
      add_query(pt(3, 3, 3), pt(10, 0, 0), pt(3, 3, 3), pt(0, 0, 10), pt(3, 3, 3));
      // full-scale tetrahedron
      add_query(pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MIN, C_MIN), pt(C_MIN, C_MAX, C_MIN),
                pt(C_MIN, C_MIN, C_MAX), pt(-16384, -16384, -16384));
      add_query(pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MIN, C_MIN), pt(C_MIN, C_MAX, C_MIN),
                pt(C_MIN, C_MIN, C_MAX), pt(C_MIN, C_MIN, C_MIN));
      add_query(pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MIN, C_MIN), pt(C_MIN, C_MAX, C_MIN),
                pt(C_MIN, C_MIN, C_MAX), pt(0, 0, 0));
      add_query(pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MIN, C_MIN), pt(C_MIN, C_MAX, C_MIN),
                pt(C_MIN, C_MIN, C_MAX), pt(C_MAX, C_MAX, C_MAX));
      add_query(pt(C_MAX, C_MAX, C_MAX), pt(C_MIN, C_MAX, C_MAX), pt(C_MAX, C_MIN, C_MAX),
                pt(C_MAX, C_MAX, C_MIN), pt(C_MAX, C_MAX, C_MAX));
      add_query(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(0, 0, 10), pt(C_MIN, C_MAX, C_MIN));
      // all-ones words: every point at (-1,-1,-1)
      ones = '1;
      pending_queries.push_back(ones);
      for (int i = 0; i < 4; i++) begin
         add_query(extreme_point(), extreme_point(), extreme_point(), extreme_point(),
                   extreme_point());
      end
      for (int i = 0; i < N_RAND; i++) add_random_query();
      total_queries = pending_queries.size();

      @(posedge clock);
      while (reset || accepted_count != total_queries) @(posedge clock);
      while (expected_locations.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d requests: %0d inside, %0d boundary, %0d outside, %0d degenerate",
               accepted_count, location_tally[LOC_INSIDE], location_tally[LOC_BOUNDARY],
               location_tally[LOC_OUTSIDE], location_tally[LOC_DEGENERATE]);
      $display("Bursty input, stalling output, %0d cycles of full output hold-off",
               hold_cycles_total);
      if (error_count == 0) begin
         $display("PASS point_in_tetrahedron_test");
      end else begin
         $display("FAIL point_in_tetrahedron_test");
      end
      $finish;
   end

   // ---------------- request driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_locations.push_back(locate_query(offered));
            location_tally[locate_query(offered)]++;
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (idle_gap > 0) begin
               idle_gap--;
               req_valid <= 1'b0;
            end else if (pending_queries.size() != 0) begin
               offered = pending_queries.pop_front();
               req_vertex_a    <= offered.a;
               req_vertex_b    <= offered.b;
               req_vertex_c    <= offered.c;
               req_vertex_d    <= offered.d;
               req_query_point <= offered.q;
               req_valid       <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- response flow control ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         hold_cycles_total++;
         rsp_ready <= 1'b0;
      end else if ((holds_done == 0 && accepted_count >= 300) ||
                   (holds_done == 1 && accepted_count >= 900)) begin
         holds_done++;
         hold_left = 90;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left <= 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 120);
            rx_mask = 8'($urandom()) | 8'h01;
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_ready <= rx_mask[0];
               rx_mask = {rx_mask[0], rx_mask[7:1]};
            end
         endcase
      end
   end

   // ---------------- response checker ----------------

   always @(posedge clock) begin
      location_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_locations.size() == 0) begin
            $error("unexpected response: location %0d with no request outstanding",
                   rsp_location);
            error_count++;
         end else begin
            want = expected_locations.pop_front();
            if (rsp_location !== want) begin
               $error("location mismatch: expected %0d (%s), actual %0d",
                      want, want.name(), rsp_location);
               error_count++;
            end
         end
      end
   end

endmodule
